>>> rtl/vcad_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vcad_pkg
// Shared field widths, colour constants and control types of the screen
// cell attribute decoder.
// ============================================================================
package vcad_pkg;

   localparam int COLUMN_W = 6;
   localparam int LINE_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int TILE_W   = 11;
   localparam int CIDX_W   = 5;
   localparam int PIXELS   = 8;

   // low resolution background sits in the upper half of the palette
   localparam logic [CIDX_W-1:0] BG_BASE   = 5'h10;
   localparam logic [CIDX_W-1:0] HI_PIXEL  = 5'd2;
   localparam logic [CIDX_W-1:0] HI_COLOR  = 5'd5;
   localparam int                BLINK_BIT = 7;

   typedef logic [CIDX_W-1:0]             cidx_type;
   typedef cidx_type [PIXELS-1:0]         cidx_row_type;
   typedef logic [2*BYTE_W-1:0]           cell_word_type;

   typedef struct packed {
      logic busy;
      logic blink_we;
   } clear_ctl_type;

endpackage

>>> rtl/vcad_if.sv
`timescale 1ns / 1ps
// ============================================================================
// vcad_if
// Channel interfaces: cell requests, decoded responses, mode register write.
// ============================================================================
interface vcad_req_if import vcad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column;
   logic [LINE_W-1:0]   line;
   logic [BYTE_W-1:0]   pixel_byte;
   logic [BYTE_W-1:0]   color_byte;
   logic                blink_on;
   logic                force_refresh;

   modport source (output valid, column, line, pixel_byte, color_byte, blink_on,
                   force_refresh, input ready);
   modport sink   (input valid, column, line, pixel_byte, color_byte, blink_on,
                   force_refresh, output ready);
endinterface

interface vcad_rsp_if import vcad_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              changed;
   logic [TILE_W-1:0] dirty_tile;
   logic [CIDX_W-1:0] pixel_0;
   logic [CIDX_W-1:0] pixel_1;
   logic [CIDX_W-1:0] pixel_2;
   logic [CIDX_W-1:0] pixel_3;
   logic [CIDX_W-1:0] pixel_4;
   logic [CIDX_W-1:0] pixel_5;
   logic [CIDX_W-1:0] pixel_6;
   logic [CIDX_W-1:0] pixel_7;

   modport source (output valid, changed, dirty_tile, pixel_0, pixel_1, pixel_2,
                   pixel_3, pixel_4, pixel_5, pixel_6, pixel_7, input ready);
   modport sink   (input valid, changed, dirty_tile, pixel_0, pixel_1, pixel_2,
                   pixel_3, pixel_4, pixel_5, pixel_6, pixel_7, output ready);
endinterface

interface vcad_csr_if ();
   logic valid;
   logic ready;
   logic hires_mode;

   modport source (output valid, hires_mode, input ready);
   modport sink   (input valid, hires_mode, output ready);
endinterface

>>> rtl/vcad_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// vcad_ram
// Generic single write, single read RAM with registered read-first output.
// ============================================================================
module vcad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/vcad_clear.sv
`timescale 1ns / 1ps
// ============================================================================
// vcad_clear
// Post-reset sweep that zeroes the cell cache and the line blink cache.
// ============================================================================
module vcad_clear import vcad_pkg::*; #(
   parameter int DEPTH = 10240,
   parameter int LINES = 256
) (
   input  logic                                      clock,
   input  logic                                      reset,
   output clear_ctl_type                             ctl,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic          busy_ff;
   logic [AW-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else if (busy_ff) begin
         if (addr_ff == AW'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            addr_ff <= addr_ff + AW'(1);
         end
      end
   end

   assign ctl.busy     = busy_ff;
   assign ctl.blink_we = busy_ff && (32'(addr_ff) < 32'(LINES));
   assign addr         = addr_ff;

endmodule

>>> rtl/vcad_pixmap.sv
`timescale 1ns / 1ps
// ============================================================================
// vcad_pixmap
// Maps a pixel byte and colour byte to eight palette indices.
// ============================================================================
module vcad_pixmap import vcad_pkg::*; (
   input  logic              hires,
   input  logic [BYTE_W-1:0] pixel_byte,
   input  logic [BYTE_W-1:0] color_byte,
   input  logic              blink_on,
   output cidx_row_type      pixels
);

   cidx_type bg;
   cidx_type fg;

   always_comb begin
      bg = BG_BASE | {2'b00, color_byte[2:0]};
      fg = {1'b0, color_byte[6:3]};
      if (color_byte[BLINK_BIT] && blink_on) begin
         fg = bg;
      end
   end

   // pixel 0 is the leftmost, taken from bit 7
   always_comb begin
      for (int k = 0; k < PIXELS; k++) begin
         if (hires) begin
            pixels[k] = (pixel_byte[PIXELS-1-k] ? HI_PIXEL : '0)
                      | (color_byte[PIXELS-1-k] ? HI_COLOR : '0);
         end else begin
            pixels[k] = pixel_byte[PIXELS-1-k] ? fg : bg;
         end
      end
   end

endmodule

>>> rtl/video_cell_attribute_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// video_cell_attribute_decoder
// Screen cell change detector and attribute colour decoder.
// ============================================================================
// Accepts one cell per clock while stage 1 can advance, and returns one
// response per cell through the stage 1 and output registers. Pixel and
// colour bytes of every cell share one 16-bit cache RAM and the per-line
// blink phase has its own RAM; each is read when the cell is accepted and
// written when the cell leaves stage 1, with the last write forwarded so
// back-to-back cells at the same address see each other. After reset a
// clearing sweep of all COLUMNS*LINES entries (10240 at the defaults) zeroes
// the caches; req.ready stays low during it, mode writes are taken at any time.
module video_cell_attribute_decoder import vcad_pkg::*; #(
   parameter int COLUMNS = 40,
   parameter int LINES   = 256
) (
   input  logic       clock,
   input  logic       reset,
   vcad_req_if.sink   req_if,
   vcad_rsp_if.source rsp_if,
   vcad_csr_if.sink   csr_if
);

   localparam int DEPTH = COLUMNS * LINES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LB_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int LX_W  = (LB_W > LINE_W) ? LB_W : LINE_W;
   localparam int PF_W  = (AW > 15) ? AW : 15;
   localparam int TF_W  = 14;

   // ---------------------------------------------------------------- config
   logic hires_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hires_ff <= 1'b0;
      end else if (csr_if.valid) begin
         hires_ff <= csr_if.hires_mode;
      end
   end

   // ---------------------------------------------------------------- clear
   clear_ctl_type clr_ctl;
   logic [AW-1:0] clr_addr;

   vcad_clear #(.DEPTH(DEPTH), .LINES(LINES)) u_clear (
      .clock (clock),
      .reset (reset),
      .ctl   (clr_ctl),
      .addr  (clr_addr)
   );

   // ---------------------------------------------------------------- stage 0
   logic            s1_valid_ff;
   logic            s1_adv;
   logic            out_valid_ff;
   logic            accept;
   logic [PF_W-1:0] req_addr_full;
   logic [AW-1:0]   req_addr;
   logic [LX_W-1:0] req_line_x;
   logic [LB_W-1:0] req_blink_addr;

   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !clr_ctl.busy && (!s1_valid_ff || s1_adv);
   assign accept       = req_if.valid && req_if.ready;

   assign req_addr_full  = PF_W'(req_if.line) * PF_W'(COLUMNS) + PF_W'(req_if.column);
   assign req_addr       = req_addr_full[AW-1:0];
   assign req_line_x     = LX_W'(req_if.line);
   assign req_blink_addr = req_line_x[LB_W-1:0];

   logic [COLUMN_W-1:0] s1_column_ff;
   logic [LINE_W-1:0]   s1_line_ff;
   logic [BYTE_W-1:0]   s1_pix_ff;
   logic [BYTE_W-1:0]   s1_col_ff;
   logic                s1_blink_ff;
   logic                s1_force_ff;
   logic                s1_in_range_ff;
   logic                s1_line_ok_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic [LB_W-1:0]     s1_blink_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_column_ff     <= req_if.column;
         s1_line_ff       <= req_if.line;
         s1_pix_ff        <= req_if.pixel_byte;
         s1_col_ff        <= req_if.color_byte;
         s1_blink_ff      <= req_if.blink_on;
         s1_force_ff      <= req_if.force_refresh;
         s1_line_ok_ff    <= 32'(req_if.line) < 32'(LINES);
         s1_in_range_ff   <= (32'(req_if.line) < 32'(LINES))
                             && (32'(req_if.column) < 32'(COLUMNS));
         s1_addr_ff       <= req_addr;
         s1_blink_addr_ff <= req_blink_addr;
      end
   end

   // ---------------------------------------------------------------- caches
   logic            cell_we;
   logic [AW-1:0]   cell_wr_addr;
   cell_word_type   cell_wr_data;
   cell_word_type   cell_rd_data;
   logic            blink_we;
   logic [LB_W-1:0] blink_wr_addr;
   logic            blink_wr_data;
   logic            blink_rd_data;
   logic            s1_cell_we;
   logic            s1_blink_we;

   assign s1_cell_we  = s1_adv && s1_in_range_ff;
   assign s1_blink_we = s1_adv && !hires_ff && s1_line_ok_ff;

   assign cell_we       = clr_ctl.busy || s1_cell_we;
   assign cell_wr_addr  = clr_ctl.busy ? clr_addr : s1_addr_ff;
   assign cell_wr_data  = clr_ctl.busy ? '0 : {s1_pix_ff, s1_col_ff};
   assign blink_we      = clr_ctl.blink_we || s1_blink_we;
   assign blink_wr_addr = clr_ctl.busy ? clr_addr[LB_W-1:0] : s1_blink_addr_ff;
   assign blink_wr_data = clr_ctl.busy ? 1'b0 : s1_blink_ff;

   vcad_ram #(.WIDTH(2 * BYTE_W), .DEPTH(DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (cell_rd_data)
   );

   vcad_ram #(.WIDTH(1), .DEPTH(LINES)) u_blink_ram (
      .clock   (clock),
      .wr_en   (blink_we),
      .wr_addr (blink_wr_addr),
      .wr_data (blink_wr_data),
      .rd_en   (accept),
      .rd_addr (req_blink_addr),
      .rd_data (blink_rd_data)
   );

   // last write of each cache, covers a read issued on the same edge
   logic            fwd_cell_valid_ff;
   logic [AW-1:0]   fwd_cell_addr_ff;
   cell_word_type   fwd_cell_data_ff;
   logic            fwd_blink_valid_ff;
   logic [LB_W-1:0] fwd_blink_addr_ff;
   logic            fwd_blink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_cell_valid_ff  <= 1'b0;
         fwd_blink_valid_ff <= 1'b0;
      end else begin
         if (s1_cell_we) begin
            fwd_cell_valid_ff <= 1'b1;
         end
         if (s1_blink_we) begin
            fwd_blink_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_cell_we) begin
         fwd_cell_addr_ff <= s1_addr_ff;
         fwd_cell_data_ff <= {s1_pix_ff, s1_col_ff};
      end
      if (s1_blink_we) begin
         fwd_blink_addr_ff <= s1_blink_addr_ff;
         fwd_blink_ff      <= s1_blink_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   cell_word_type cell_old;
   logic          blink_old;
   logic          lbc_ff;
   logic          lbc_in;
   logic          changed;

   assign cell_old  = (fwd_cell_valid_ff && (fwd_cell_addr_ff == s1_addr_ff))
                      ? fwd_cell_data_ff : cell_rd_data;
   assign blink_old = (fwd_blink_valid_ff && (fwd_blink_addr_ff == s1_blink_addr_ff))
                      ? fwd_blink_ff : blink_rd_data;

   always_comb begin
      lbc_in = lbc_ff;
      if (!hires_ff) begin
         if (s1_column_ff == '0) begin
            lbc_in = 1'b0;
         end
         if (s1_line_ok_ff && (blink_old != s1_blink_ff)) begin
            lbc_in = 1'b1;
         end
      end
   end

   assign changed = s1_force_ff
                  || (s1_in_range_ff && (cell_old != {s1_pix_ff, s1_col_ff}))
                  || (s1_in_range_ff && !hires_ff && s1_col_ff[BLINK_BIT] && lbc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         lbc_ff <= 1'b0;
      end else if (s1_adv) begin
         lbc_ff <= lbc_in;
      end
   end

   logic [TF_W-1:0] tile_full;
   cidx_row_type    s1_pixels;

   assign tile_full = TF_W'(s1_line_ff[LINE_W-1:3]) * TF_W'(COLUMNS) + TF_W'(s1_column_ff);

   vcad_pixmap u_pixmap (
      .hires      (hires_ff),
      .pixel_byte (s1_pix_ff),
      .color_byte (s1_col_ff),
      .blink_on   (s1_blink_ff),
      .pixels     (s1_pixels)
   );

   // ---------------------------------------------------------------- output
   logic              out_changed_ff;
   logic [TILE_W-1:0] out_tile_ff;
   cidx_row_type      out_pixels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // an unchanged cell reports all fields zero
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_changed_ff <= changed;
         out_tile_ff    <= changed ? tile_full[TILE_W-1:0] : '0;
         out_pixels_ff  <= changed ? s1_pixels : '0;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.changed    = out_changed_ff;
   assign rsp_if.dirty_tile = out_tile_ff;
   assign rsp_if.pixel_0    = out_pixels_ff[0];
   assign rsp_if.pixel_1    = out_pixels_ff[1];
   assign rsp_if.pixel_2    = out_pixels_ff[2];
   assign rsp_if.pixel_3    = out_pixels_ff[3];
   assign rsp_if.pixel_4    = out_pixels_ff[4];
   assign rsp_if.pixel_5    = out_pixels_ff[5];
   assign rsp_if.pixel_6    = out_pixels_ff[6];
   assign rsp_if.pixel_7    = out_pixels_ff[7];

endmodule
